/* src/pbb_pkg.sv */
package pbb_pkg;

  localparam int unsigned MaxWindow = 64;
  localparam int unsigned SlotW = $clog2(MaxWindow);
  localparam int unsigned LenW = 7;
  localparam int unsigned SumW = 8 + SlotW + 1;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [SumW-1:0] sum_red;
    logic [SumW-1:0] sum_green;
    logic [SumW-1:0] sum_blue;
    logic [LenW-1:0] len;
    logic            last;
  } job_t;

  typedef enum logic [2:0] {
    DivIdle = 3'b001,
    DivRun  = 3'b010,
    DivDone = 3'b100
  } div_state_e;

endpackage

/* src/pbb_front.sv */
module pbb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pbb_pkg::pixel_t in_pix_i,
  input  logic            in_last_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output pbb_pkg::job_t   job_o
);

  logic [pbb_pkg::LenW-1:0]  len_q;
  logic [pbb_pkg::LenW-1:0]  eff_len;
  logic [pbb_pkg::LenW-1:0]  fill_q;
  logic [pbb_pkg::SlotW-1:0] slot_q;
  logic [pbb_pkg::SumW-1:0]  sr_q, sg_q, sb_q;
  pbb_pkg::pixel_t           mem_q [pbb_pkg::MaxWindow];
  pbb_pkg::pixel_t           old_q;
  logic                      st_q;
  pbb_pkg::pixel_t           pix_q;
  logic                      last_q;
  logic                      full_q;
  logic [pbb_pkg::SumW-1:0]  nr, ng, nb;
  logic [pbb_pkg::LenW-1:0]  slot_nx;
  logic                      fire;

  always_comb begin
    eff_len = len_q;
    if (len_q == '0) eff_len = pbb_pkg::LenW'(1);
    if (len_q > pbb_pkg::LenW'(pbb_pkg::MaxWindow)) eff_len = pbb_pkg::LenW'(pbb_pkg::MaxWindow);
  end

  // stage 1 reads old entry; stage 2 updates sums
  assign in_ready_o = !st_q || job_ready_i;
  assign fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      old_q <= mem_q[slot_q];
      mem_q[slot_q] <= in_pix_i;
      pix_q <= in_pix_i;
      last_q <= in_last_i;
      full_q <= (fill_q >= eff_len);
    end
  end

  always_comb begin
    nr = sr_q + pbb_pkg::SumW'(pix_q.red);
    ng = sg_q + pbb_pkg::SumW'(pix_q.green);
    nb = sb_q + pbb_pkg::SumW'(pix_q.blue);
    if (full_q) begin
      nr = nr - pbb_pkg::SumW'(old_q.red);
      ng = ng - pbb_pkg::SumW'(old_q.green);
      nb = nb - pbb_pkg::SumW'(old_q.blue);
    end
    slot_nx = pbb_pkg::LenW'(slot_q) + pbb_pkg::LenW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= pbb_pkg::LenW'(1);
      fill_q <= '0;
      slot_q <= '0;
      sr_q <= '0;
      sg_q <= '0;
      sb_q <= '0;
      st_q <= 1'b0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
      fill_q <= '0;
      slot_q <= '0;
      sr_q <= '0;
      sg_q <= '0;
      sb_q <= '0;
    end else begin
      if (st_q && job_ready_i) begin
        sr_q <= last_q ? '0 : nr;
        sg_q <= last_q ? '0 : ng;
        sb_q <= last_q ? '0 : nb;
      end
      if (fire) begin
        if (in_last_i) begin
          fill_q <= '0;
          slot_q <= '0;
        end else begin
          slot_q <= (slot_nx >= eff_len) ? '0 : slot_nx[pbb_pkg::SlotW-1:0];
          if (fill_q < eff_len) fill_q <= fill_q + pbb_pkg::LenW'(1);
        end
      end
      if (fire) st_q <= 1'b1;
      else if (job_ready_i) st_q <= 1'b0;
    end
  end

  // result exists once window is full after this pixel
  logic had_full_q;
  always_ff @(posedge clk_i) begin
    if (fire) had_full_q <= (fill_q + pbb_pkg::LenW'(1) >= eff_len);
  end

  assign job_valid_o = st_q && had_full_q;
  assign job_o.sum_red = nr;
  assign job_o.sum_green = ng;
  assign job_o.sum_blue = nb;
  assign job_o.len = eff_len;
  assign job_o.last = last_q;

endmodule

/* src/pbb_queue.sv */
module pbb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  pbb_pkg::job_t data_i,
  output logic          valid_o,
  input  logic          pop_i,
  output pbb_pkg::job_t data_o
);

  pbb_pkg::job_t mem_q [pbb_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && ready_o) wp_q <= !wp_q;
      if (pop_i && valid_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'((push_i && ready_o) ? 1 : 0) - 2'((pop_i && valid_o) ? 1 : 0);
    end
  end

endmodule

/* src/pbb_back.sv */
module pbb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  pbb_pkg::job_t job_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    avg_red_o,
  output logic [7:0]    avg_green_o,
  output logic [7:0]    avg_blue_o,
  output logic          final_average_o
);

  localparam int unsigned SumW = pbb_pkg::SumW;
  localparam int unsigned CntW = $clog2(SumW + 1);

  pbb_pkg::div_state_e state_q;
  logic [SumW-1:0] qr_q, qg_q, qb_q;
  logic [pbb_pkg::LenW-1:0] rr_q, rg_q, rb_q, den_q;
  logic [CntW-1:0] bit_q;
  logic last_q;
  logic [pbb_pkg::LenW:0] tr, tg, tb;

  // restoring division, one quotient bit a cycle per channel
  always_comb begin
    tr = {rr_q, qr_q[SumW-1]};
    tg = {rg_q, qg_q[SumW-1]};
    tb = {rb_q, qb_q[SumW-1]};
  end

  assign job_pop_o = (state_q == pbb_pkg::DivIdle) && job_valid_i;
  assign empty_o = state_q != pbb_pkg::DivDone;
  assign avg_red_o = qr_q[7:0];
  assign avg_green_o = qg_q[7:0];
  assign avg_blue_o = qb_q[7:0];
  assign final_average_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbb_pkg::DivIdle;
      bit_q <= '0;
    end else begin
      case (state_q)
        pbb_pkg::DivIdle: begin
          if (job_valid_i) begin
            state_q <= pbb_pkg::DivRun;
            bit_q <= CntW'(SumW);
          end
        end
        pbb_pkg::DivRun: begin
          bit_q <= bit_q - CntW'(1);
          if (bit_q == CntW'(1)) state_q <= pbb_pkg::DivDone;
        end
        pbb_pkg::DivDone: begin
          if (pop_i) state_q <= pbb_pkg::DivIdle;
        end
        default: state_q <= pbb_pkg::DivIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pbb_pkg::DivIdle) begin
      qr_q <= job_i.sum_red;
      qg_q <= job_i.sum_green;
      qb_q <= job_i.sum_blue;
      rr_q <= '0;
      rg_q <= '0;
      rb_q <= '0;
      den_q <= job_i.len;
      last_q <= job_i.last;
    end else if (state_q == pbb_pkg::DivRun) begin
      if (tr >= {1'b0, den_q}) begin
        rr_q <= pbb_pkg::LenW'(tr - {1'b0, den_q});
        qr_q <= {qr_q[SumW-2:0], 1'b1};
      end else begin
        rr_q <= tr[pbb_pkg::LenW-1:0];
        qr_q <= {qr_q[SumW-2:0], 1'b0};
      end
      if (tg >= {1'b0, den_q}) begin
        rg_q <= pbb_pkg::LenW'(tg - {1'b0, den_q});
        qg_q <= {qg_q[SumW-2:0], 1'b1};
      end else begin
        rg_q <= tg[pbb_pkg::LenW-1:0];
        qg_q <= {qg_q[SumW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den_q}) begin
        rb_q <= pbb_pkg::LenW'(tb - {1'b0, den_q});
        qb_q <= {qb_q[SumW-2:0], 1'b1};
      end else begin
        rb_q <= tb[pbb_pkg::LenW-1:0];
        qb_q <= {qb_q[SumW-2:0], 1'b0};
      end
    end
  end

endmodule

/* src/pixel_box_blur_1d_top.sv */
// Channel  Direction  Handshake            Payload
// pixel    in         push / full          pix_red/green/blue, end_of_image
// average  out        pop / empty          avg_red/green/blue, final_average
// config   in         cfg_we               cfg_wdata (window_length)
// A pixel is taken each cycle until the two-entry job queue fills.
// Each average is computed in the bit-serial divider, which runs the three channels
// in parallel and takes the next job only once its result has been popped.
// Reset is asynchronous; window length resets to 1 with sums cleared.
// A stalled pop holds the divider, then the queue, then full.
module pixel_box_blur_1d_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pix_red_i,
  input  logic [7:0] pix_green_i,
  input  logic [7:0] pix_blue_i,
  input  logic       end_of_image_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] avg_red_o,
  output logic [7:0] avg_green_o,
  output logic [7:0] avg_blue_o,
  output logic       final_average_o
);

  pbb_pkg::pixel_t pix;
  pbb_pkg::job_t   job, qjob;
  logic in_ready, job_valid, q_ready, q_valid, q_pop;

  assign pix.red = pix_red_i;
  assign pix.green = pix_green_i;
  assign pix.blue = pix_blue_i;
  assign full = !in_ready;

  pbb_front u_front (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(push), .in_ready_o(in_ready),
    .in_pix_i(pix), .in_last_i(end_of_image_i),
    .job_valid_o(job_valid), .job_ready_i(q_ready), .job_o(job)
  );

  pbb_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(job_valid), .ready_o(q_ready), .data_i(job),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(qjob)
  );

  pbb_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_pop_o(q_pop), .job_i(qjob),
    .empty_o(empty), .pop_i(pop),
    .avg_red_o, .avg_green_o, .avg_blue_o, .final_average_o
  );

endmodule

/* test/pixel_box_blur_1d_top_tb.sv */
`timescale 1ns / 1ps

module pixel_box_blur_1d_top_tb;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } avg_beat_t;

  localparam int unsigned StallLimit = 5000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  logic       push;
  logic       full;
  logic [7:0] pix_red_i;
  logic [7:0] pix_green_i;
  logic [7:0] pix_blue_i;
  logic       end_of_image_i;
  logic       empty;
  logic       pop;
  logic [7:0] avg_red_o;
  logic [7:0] avg_green_o;
  logic [7:0] avg_blue_o;
  logic       final_average_o;

  pbb_pkg::pixel_t line_buf [pbb_pkg::MaxWindow];
  int unsigned     acc_red;
  int unsigned     acc_green;
  int unsigned     acc_blue;
  int unsigned     held_cnt;
  int unsigned     next_slot;
  logic [6:0]      blur_len;
  avg_beat_t       avg_queue [$];
  int unsigned     err_cnt;
  int unsigned     pix_cnt;
  int unsigned     avg_cnt;
  int unsigned     idle_cnt;
  bit              src_gaps;
  bit              sink_gaps;

  pixel_box_blur_1d_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .pix_red_i      (pix_red_i),
    .pix_green_i    (pix_green_i),
    .pix_blue_i     (pix_blue_i),
    .end_of_image_i (end_of_image_i),
    .empty          (empty),
    .pop            (pop),
    .avg_red_o      (avg_red_o),
    .avg_green_o    (avg_green_o),
    .avg_blue_o     (avg_blue_o),
    .final_average_o(final_average_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len();
    int unsigned len;
    len = blur_len;
    if (len == 0) len = 1;
    if (len > pbb_pkg::MaxWindow) len = pbb_pkg::MaxWindow;
    return len;
  endfunction

  function automatic void clear_line();
    acc_red = 0;
    acc_green = 0;
    acc_blue = 0;
    held_cnt = 0;
    next_slot = 0;
  endfunction

  function automatic void predict_avg(pbb_pkg::pixel_t px, logic last);
    int unsigned len;
    int unsigned slot;
    avg_beat_t   exp_beat;
    len = eff_len();
    slot = (next_slot >= len) ? 0 : next_slot;
    if (held_cnt >= len) begin
      acc_red -= line_buf[slot].red;
      acc_green -= line_buf[slot].green;
      acc_blue -= line_buf[slot].blue;
    end
    line_buf[slot] = px;
    acc_red += px.red;
    acc_green += px.green;
    acc_blue += px.blue;
    slot++;
    next_slot = (slot >= len) ? 0 : slot;
    if (held_cnt < len) held_cnt++;
    if (held_cnt >= len) begin
      exp_beat.red = 8'(acc_red / len);
      exp_beat.green = 8'(acc_green / len);
      exp_beat.blue = 8'(acc_blue / len);
      exp_beat.last = last;
      avg_queue.push_back(exp_beat);
    end
    if (last) clear_line();
  endfunction

  task automatic wait_drain();
    push <= 1'b0;
    while (avg_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_blur_len(logic [6:0] len);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    blur_len = len;
    clear_line();
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    pbb_pkg::pixel_t px;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    push <= 1'b1;
    pix_red_i <= r;
    pix_green_i <= g;
    pix_blue_i <= b;
    end_of_image_i <= last;
    do @(posedge clk_i); while (full);
    px.red = r;
    px.green = g;
    px.blue = b;
    predict_avg(px, last);
    pix_cnt++;
  endtask

  task automatic send_image(int unsigned n, bit extreme);
    for (int unsigned i = 0; i < n; i++) begin
      if (extreme)
        send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
                   $urandom_range(0, 1) ? 8'hff : 8'h00, i == n - 1);
      else
        send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_blur_len(7'd1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'haa, 8'h55, 8'h0f, 1'b1);
    set_blur_len(7'd0);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    set_blur_len(7'd3);
    send_image(2, 1'b0);
    send_image(5, 1'b1);
    set_blur_len(7'd127);
    send_image(8, 1'b0);
  endtask

  task automatic test_max_window();
    set_blur_len(7'd64);
    for (int unsigned i = 0; i < 70; i++) send_pixel(8'hff, 8'hff, 8'hff, i == 69);
    set_blur_len(7'd65);
    send_image(66, 1'b0);
  endtask

  task automatic test_random_images();
    for (int k = 0; k < 40; k++) begin
      if (k % 8 == 0) set_blur_len(7'($urandom_range(1, 12)));
      send_image($urandom_range(1, 14), $urandom_range(0, 4) == 0);
      if (k == 20) wait_drain();
    end
  endtask

  task automatic test_no_gaps();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    set_blur_len(7'd4);
    send_image(60, 1'b0);
  endtask

  always @(posedge clk_i) begin
    avg_beat_t exp_beat;
    if (rst_ni && pop && !empty) begin
      avg_cnt++;
      if (avg_queue.size() == 0) begin
        $error("average beat with nothing expected");
        err_cnt++;
      end else begin
        exp_beat = avg_queue.pop_front();
        if (avg_red_o !== exp_beat.red) begin
          $error("avg_red exp %0d got %0d", exp_beat.red, avg_red_o);
          err_cnt++;
        end
        if (avg_green_o !== exp_beat.green) begin
          $error("avg_green exp %0d got %0d", exp_beat.green, avg_green_o);
          err_cnt++;
        end
        if (avg_blue_o !== exp_beat.blue) begin
          $error("avg_blue exp %0d got %0d", exp_beat.blue, avg_blue_o);
          err_cnt++;
        end
        if (final_average_o !== exp_beat.last) begin
          $error("final_average exp %0d got %0d", exp_beat.last, final_average_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= StallLimit) begin
      $display("[pixel_box_blur_1d_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    push = 1'b0;
    pix_red_i = '0;
    pix_green_i = '0;
    pix_blue_i = '0;
    end_of_image_i = 1'b0;
    err_cnt = 0;
    pix_cnt = 0;
    avg_cnt = 0;
    idle_cnt = 0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    blur_len = 7'd1;
    clear_line();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_max_window();
    test_random_images();
    test_no_gaps();
    wait_drain();
    $display("pixels sent %0d, averages checked %0d, windows 0..127 incl. extremes",
             pix_cnt, avg_cnt);
    if (err_cnt == 0) $display("[pixel_box_blur_1d_top] OK");
    else $display("[pixel_box_blur_1d_top] ERROR");
    $finish;
  end

endmodule

/* pixel_box_blur_1d_top.f */
src/pbb_pkg.sv
src/pbb_front.sv
src/pbb_queue.sv
src/pbb_back.sv
src/pixel_box_blur_1d_top.sv
test/pixel_box_blur_1d_top_tb.sv
